// ===== rtl/hbvs_pkg.sv =====
// Shared types and constants for the hashed bucket value set.
// Used by hbvs_ctrl, hbvs_dp and the top level; depends on nothing.
package hbvs_pkg;

    localparam int KEY_W     = 31;
    localparam int VALUE_W   = 32;
    localparam int OP_W      = 2;

    // Key modulo: reciprocal multiply, then multiply back and subtract
    localparam int MOD_STEPS = 2;
    localparam int STEP_W    = 1;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    // Controller states, one-hot
    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_MOD    = 6'b000100,
        ST_BASE   = 6'b001000,
        ST_SCAN   = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic clr_step;   // zero one memory word, advance clear pointer
        logic load;       // capture the request
        logic mod_step;   // advance the key reduction by one step
        logic base_load;  // form the bucket base address
        logic scan_step;  // read one slot of the bucket
        logic commit;     // place an insert, load the result register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic mod_last;
        logic scan_last;
        logic rd_busy;    // a slot read is still being checked
    } stat_t;

endpackage

// ===== rtl/hbvs_ctrl.sv =====
// Sequencer for the hashed bucket value set: clear pass, key reduction,
// bucket scan and result handoff. Depends on hbvs_pkg.
module hbvs_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  hbvs_pkg::stat_t stat,
    output hbvs_pkg::cmd_t  cmd
);

    hbvs_pkg::state_t state_reg;
    hbvs_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            hbvs_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = hbvs_pkg::ST_IDLE;
                end
            end
            hbvs_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = hbvs_pkg::ST_MOD;
                end
            end
            hbvs_pkg::ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (stat.mod_last)
                begin
                    state_next = hbvs_pkg::ST_BASE;
                end
            end
            hbvs_pkg::ST_BASE:
            begin
                cmd.base_load = 1'b1;
                state_next    = hbvs_pkg::ST_SCAN;
            end
            hbvs_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = hbvs_pkg::ST_FINISH;
                end
            end
            hbvs_pkg::ST_FINISH:
            begin
                // wait for the last slot check and a free result register, then hand off the result
                if (!stat.rd_busy && out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = hbvs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hbvs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hbvs_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/hbvs_dp.sv =====
// Datapath for the hashed bucket value set: request registers, key modulo
// reducer, slot memory with valid marks, slot compare and result registers.
// Depends on hbvs_pkg.
module hbvs_dp
#(
    parameter int NUM_BUCKETS  = 16,
    parameter int BUCKET_DEPTH = 8
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  hbvs_pkg::cmd_t               cmd,
    output hbvs_pkg::stat_t              stat,
    input  logic [hbvs_pkg::OP_W-1:0]    op,
    input  logic [hbvs_pkg::KEY_W-1:0]   key,
    input  logic signed [hbvs_pkg::VALUE_W-1:0] value,
    output logic                         found,
    output logic                         status
);

    localparam int SLOT_COUNT = NUM_BUCKETS * BUCKET_DEPTH;
    localparam int ADDR_W     = $clog2(SLOT_COUNT);
    localparam int IDX_W      = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int REM_W      = $clog2(NUM_BUCKETS);
    localparam int WORD_W     = hbvs_pkg::VALUE_W + 1;

    // floor(key / N) = (key * RECIP_M) >> RECIP_SH, exact for every 31-bit key
    localparam int RECIP_SH   = hbvs_pkg::KEY_W + REM_W;
    localparam int RECIP_W    = 32;
    localparam int PROD_W     = hbvs_pkg::KEY_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RECIP_SH) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS);
    localparam logic [RECIP_W-1:0] RECIP_M = RECIP_FULL[RECIP_W-1:0];

    // word = {valid, value}
    logic [WORD_W-1:0]                mem [SLOT_COUNT];
    logic [WORD_W-1:0]                rd_word_reg;

    logic [hbvs_pkg::OP_W-1:0]        op_reg;
    logic [hbvs_pkg::KEY_W-1:0]       key_reg;
    logic [PROD_W-1:0]                prod_reg;
    logic [hbvs_pkg::VALUE_W-1:0]     value_reg;
    logic [REM_W-1:0]                 rem_reg;
    logic [REM_W-1:0]                 rem_next;
    logic [hbvs_pkg::STEP_W-1:0]      step_reg;
    logic [ADDR_W-1:0]                base_reg;
    logic [IDX_W-1:0]                 idx_reg;
    logic [ADDR_W-1:0]                rd_addr_reg;
    logic                             rd_valid_reg;
    logic                             free_found_reg;
    logic [ADDR_W-1:0]                free_addr_reg;
    logic                             hit_reg;
    logic [ADDR_W-1:0]                clr_cnt_reg;
    logic                             found_reg;
    logic                             status_reg;

    logic [hbvs_pkg::KEY_W-1:0]       quot;
    logic [hbvs_pkg::KEY_W-1:0]       rem_full;
    logic [ADDR_W-1:0]                rd_addr;
    logic                             slot_hit;
    logic                             slot_free;
    logic                             we;
    logic [ADDR_W-1:0]                waddr;
    logic [WORD_W-1:0]                wdata;

    // Second reduction step: remainder = key - quotient * N
    always_comb
    begin
        quot     = hbvs_pkg::KEY_W'(prod_reg >> RECIP_SH);
        rem_full = key_reg - hbvs_pkg::KEY_W'(quot * hbvs_pkg::KEY_W'(NUM_BUCKETS));
        rem_next = REM_W'(rem_full);
    end

    assign rd_addr   = base_reg + ADDR_W'(idx_reg);
    assign slot_hit  = rd_word_reg[WORD_W-1] &&
                       (rd_word_reg[hbvs_pkg::VALUE_W-1:0] == value_reg);
    assign slot_free = !rd_word_reg[WORD_W-1];

    // Single write port: clear pass, delete on match, insert placement
    always_comb
    begin
        we    = 1'b0;
        waddr = clr_cnt_reg;
        wdata = '0;
        if (cmd.clr_step)
        begin
            we = 1'b1;
        end
        else if (rd_valid_reg && (op_reg == hbvs_pkg::OP_DELETE) && slot_hit)
        begin
            we    = 1'b1;
            waddr = rd_addr_reg;
            wdata = {1'b0, rd_word_reg[hbvs_pkg::VALUE_W-1:0]};
        end
        else if (cmd.commit && (op_reg == hbvs_pkg::OP_INSERT) && free_found_reg)
        begin
            we    = 1'b1;
            waddr = free_addr_reg;
            wdata = {1'b1, value_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.scan_step)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    // Request payload, key product, bucket base, read address and free-slot address
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= op;
            value_reg <= value;
            key_reg   <= key;
        end
        if (cmd.mod_step)
        begin
            prod_reg <= PROD_W'(key_reg) * PROD_W'(RECIP_M);
        end
        if (cmd.base_load)
        begin
            base_reg <= ADDR_W'(rem_reg) * ADDR_W'(BUCKET_DEPTH);
        end
        if (cmd.scan_step)
        begin
            rd_addr_reg <= rd_addr;
        end
        if (rd_valid_reg && slot_free && !free_found_reg)
        begin
            free_addr_reg <= rd_addr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg        <= '0;
            step_reg       <= '0;
            idx_reg        <= '0;
            rd_valid_reg   <= 1'b0;
            free_found_reg <= 1'b0;
            hit_reg        <= 1'b0;
            clr_cnt_reg    <= '0;
            found_reg      <= 1'b0;
            status_reg     <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.scan_step;
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.load)
            begin
                rem_reg        <= '0;
                step_reg       <= '0;
                free_found_reg <= 1'b0;
                hit_reg        <= 1'b0;
            end
            else if (cmd.mod_step)
            begin
                step_reg <= step_reg + 1'b1;
                if (stat.mod_last)
                begin
                    rem_reg <= rem_next;
                end
            end
            if (cmd.base_load)
            begin
                idx_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (rd_valid_reg)
            begin
                if (slot_free)
                begin
                    free_found_reg <= 1'b1;
                end
                if (slot_hit)
                begin
                    hit_reg <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                found_reg  <= (op_reg == hbvs_pkg::OP_SEARCH) && hit_reg;
                status_reg <= (op_reg == hbvs_pkg::OP_INSERT) && !free_found_reg;
            end
        end
    end

    assign stat.clr_last  = (clr_cnt_reg == ADDR_W'(SLOT_COUNT - 1));
    assign stat.mod_last  = (step_reg == hbvs_pkg::STEP_W'(hbvs_pkg::MOD_STEPS - 1));
    assign stat.scan_last = (idx_reg == IDX_W'(BUCKET_DEPTH - 1));
    assign stat.rd_busy   = rd_valid_reg;

    assign found  = found_reg;
    assign status = status_reg;

endmodule

// ===== rtl/hashed_bucket_value_set_top.sv =====
// Top level of the hashed bucket value set: a value set split into buckets
// by key modulo NUM_BUCKETS. Instantiates hbvs_ctrl and hbvs_dp; uses hbvs_pkg.
//
//   channel   signals                      direction  carries
//   --------  ---------------------------  ---------  ------------------------------
//   request   in_valid/in_ready op key value  in      insert, delete-all or search
//   result    out_valid/out_ready found status out    search hit, insert-full flag
//
// Steps: each request passes through accept, key modulo (reciprocal multiply,
//   then multiply back and subtract), base address, bucket scan (one slot read
//   a cycle from the slot memory), last slot check and result load; in_ready
//   is high again right after.
// Reset: after rst_n releases, a clearing pass zeroes all
//   NUM_BUCKETS*BUCKET_DEPTH slot words, one a cycle; in_ready stays low for it.
// Stalls: a result waits in the output register while the next request is
//   accepted and worked on; that request holds in its last step until the
//   result register frees.
module hashed_bucket_value_set_top
#(
    parameter int NUM_BUCKETS  = 16,
    parameter int BUCKET_DEPTH = 8
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [hbvs_pkg::OP_W-1:0]          op,
    input  logic [hbvs_pkg::KEY_W-1:0]         key,
    input  logic signed [hbvs_pkg::VALUE_W-1:0] value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               found,
    output logic                               status
);

    hbvs_pkg::cmd_t  cmd;
    hbvs_pkg::stat_t stat;

    // Sequencer: owns the handshakes and steps the datapath
    hbvs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: slot memory, modulo reducer, compare and result registers
    hbvs_dp
    #(
        .NUM_BUCKETS  (NUM_BUCKETS),
        .BUCKET_DEPTH (BUCKET_DEPTH)
    )
    u_dp
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .stat   (stat),
        .op     (op),
        .key    (key),
        .value  (value),
        .found  (found),
        .status (status)
    );

endmodule

// ===== rtl/hbvs_checker.sv =====
// Port-level checks for hashed_bucket_value_set_top, bound to the top level.
// Depends on hbvs_pkg for field widths.
module hbvs_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic [hbvs_pkg::OP_W-1:0]          op,
    input logic [hbvs_pkg::KEY_W-1:0]         key,
    input logic signed [hbvs_pkg::VALUE_W-1:0] value,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic                               found,
    input logic                               status
);

    // Hold a waiting request
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(op) && $stable(key) && $stable(value))
        else $error("waiting request changed");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found) && $stable(status))
        else $error("stalled result changed");

    // Drop readiness once a request is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while another is in work");

    // A full-bucket drop is never a search hit
    a_status_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(found && status))
        else $error("found and status both set");

    // A fresh result appears as the block goes back to waiting for requests
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result raised while busy");

endmodule

bind hashed_bucket_value_set_top hbvs_checker u_hbvs_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .key       (key),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .found     (found),
    .status    (status)
);

// ===== verif/tb.sv =====
// Self-checking testbench for hashed_bucket_value_set_top.
// Holds its own bucket model and drives the request channel from a directed table
// and then from random traffic. Depends on hbvs_pkg and the RTL top level only.
`timescale 1ns / 100ps

module tb;

    localparam int NUM_BUCKETS  = 16;
    localparam int BUCKET_DEPTH = 8;
    localparam int SLOT_COUNT   = NUM_BUCKETS * BUCKET_DEPTH;

    // Op code 3 is not defined by the block; it must act as a no-op
    localparam logic [hbvs_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_ITEMS  = 625;
    localparam int QUIET_ITEMS   = 80;     // tail of the run with no idling
    localparam int STUCK_LIMIT   = 2000;   // cycles with no handshake at all
    localparam int DRAIN_CYCLES  = 30;     // settle time after the last result
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic found;
        logic status;
    } result_t;

    // One row of the directed table; typed rows carry their own expectation
    typedef struct packed {
        logic [hbvs_pkg::OP_W-1:0]    op;
        logic [hbvs_pkg::KEY_W-1:0]   key;
        logic [hbvs_pkg::VALUE_W-1:0] value;
        logic                         typed;
        logic                         found;
        logic                         status;
    } stim_row_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    logic [hbvs_pkg::OP_W-1:0]    op;
    logic [hbvs_pkg::KEY_W-1:0]   key;
    logic [hbvs_pkg::VALUE_W-1:0] value;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic                         found;
    logic                         status;

    // Shadow copy of the slot store
    logic                         shadow_valid [SLOT_COUNT];
    logic [hbvs_pkg::VALUE_W-1:0] shadow_value [SLOT_COUNT];

    result_t                      pending_results [$];
    stim_row_t                    directed_rows [DIRECTED_ROWS];
    logic [hbvs_pkg::VALUE_W-1:0] value_pool [8];

    int  mismatches       = 0;
    int  results_seen     = 0;
    int  stuck_cycles     = 0;
    int  ready_stall_left = 0;
    bit  quiet_phase;

    hashed_bucket_value_set_top
    #(
        .NUM_BUCKETS  (NUM_BUCKETS),
        .BUCKET_DEPTH (BUCKET_DEPTH)
    )
    dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .key       (key),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .found     (found),
        .status    (status)
    );

    always #2 clk = ~clk;

    // Apply one request to the shadow store and return the result it must give.
    // Insert takes the lowest free slot of the bucket, or reports full; delete
    // drops every copy of the value; search looks for any valid copy.
    function automatic result_t set_apply(logic [hbvs_pkg::OP_W-1:0] op_i,
                                          logic [hbvs_pkg::KEY_W-1:0] key_i,
                                          logic [hbvs_pkg::VALUE_W-1:0] val_i);
        result_t r;
        int      base;
        bit      placed;
        r      = '0;
        placed = 1'b0;
        base   = int'(key_i % hbvs_pkg::KEY_W'(NUM_BUCKETS)) * BUCKET_DEPTH;
        case (op_i)
            hbvs_pkg::OP_INSERT:
            begin
                for (int i = 0; i < BUCKET_DEPTH; i++)
                begin
                    if (!placed && !shadow_valid[base + i])
                    begin
                        shadow_valid[base + i] = 1'b1;
                        shadow_value[base + i] = val_i;
                        placed                 = 1'b1;
                    end
                end
                r.status = !placed;
            end
            hbvs_pkg::OP_DELETE:
            begin
                for (int i = 0; i < BUCKET_DEPTH; i++)
                begin
                    if (shadow_valid[base + i] && shadow_value[base + i] == val_i)
                        shadow_valid[base + i] = 1'b0;
                end
            end
            hbvs_pkg::OP_SEARCH:
            begin
                for (int i = 0; i < BUCKET_DEPTH; i++)
                begin
                    if (shadow_valid[base + i] && shadow_value[base + i] == val_i)
                        r.found = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Append one expectation to the tail of the pending list
    task automatic expect_result(input result_t r);
        pending_results.insert(pending_results.size(), r);
    endtask

    // Present one request at the falling edge and hold it until accepted. Valid
    // stays high on return so back-to-back requests need no extra edge.
    task automatic send_request(input logic [hbvs_pkg::OP_W-1:0] op_i,
                                input logic [hbvs_pkg::KEY_W-1:0] key_i,
                                input logic [hbvs_pkg::VALUE_W-1:0] val_i,
                                input logic typed,
                                input logic typed_found, input logic typed_status);
        result_t predicted;
        @(negedge clk);
        in_valid <= 1'b1;
        op       <= op_i;
        key      <= key_i;
        value    <= val_i;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = set_apply(op_i, key_i, val_i);
        if (typed)
            expect_result(result_t'{typed_found, typed_status});
        else
            expect_result(predicted);
    endtask

    // Drop valid for a burst of idle cycles
    task automatic idle_sender(input int cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles - 1)
            @(negedge clk);
    endtask

    // Receiver: stall in random bursts, never in the quiet tail
    always @(negedge clk)
    begin
        if (!rst_n || quiet_phase)
        begin
            out_ready <= 1'b1;
            ready_stall_left = 0;
        end
        else if (ready_stall_left > 0)
        begin
            out_ready <= 1'b0;
            ready_stall_left = ready_stall_left - 1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            out_ready <= 1'b0;
            ready_stall_left = $urandom_range(0, 9);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest expectation, field by field
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result %0d: no request pending, got found=%0b status=%0b",
                             results_seen, found, status);
            end
            else
            begin
                want = pending_results.pop_front();
                if (found !== want.found)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("result %0d: found expected %0b, got %0b",
                                 results_seen, want.found, found);
                end
                if (status !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("result %0d: status expected %0b, got %0b",
                                 results_seen, want.status, status);
                end
            end
        end
    end

    // Watchdog: advance only while some handshake keeps happening
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stuck_cycles = 0;
        else
            stuck_cycles = stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("[hashed_bucket_value_set_top] ERROR");
            $finish;
        end
    end

    initial
    begin
        int                           r;
        int                           mix;
        int                           bucket;
        logic [hbvs_pkg::OP_W-1:0]    rand_op;
        logic [hbvs_pkg::KEY_W-1:0]   rand_key;
        logic [hbvs_pkg::VALUE_W-1:0] rand_val;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        op          = '0;
        key         = '0;
        value       = '0;
        quiet_phase = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_value[i] = '0;
        end

        // Directed table. Bucket 0 gets filled with the value extremes and a
        // duplicate, then overflowed; delete-all frees room for new inserts.
        directed_rows = '{
            // empty store after reset, delete of an absent value, unused op
            '{hbvs_pkg::OP_SEARCH, 31'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 1'b0},
            '{hbvs_pkg::OP_DELETE, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0},
            '{OP_UNUSED,           31'h0000_0005, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0},
            // fill bucket 0, one duplicate among them
            '{hbvs_pkg::OP_INSERT, 31'h0000_0000, 32'h8000_0000, 1'b1, 1'b0, 1'b0},
            '{hbvs_pkg::OP_INSERT, 31'h0000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0},
            '{hbvs_pkg::OP_INSERT, 31'h0000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0},
            '{hbvs_pkg::OP_INSERT, 31'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 1'b0},
            '{hbvs_pkg::OP_INSERT, 31'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0},
            '{hbvs_pkg::OP_INSERT, 31'h0000_0000, 32'h0000_0001, 1'b1, 1'b0, 1'b0},
            '{hbvs_pkg::OP_INSERT, 31'h0000_0000, 32'h5555_5555, 1'b1, 1'b0, 1'b0},
            '{hbvs_pkg::OP_INSERT, 31'h0000_0000, 32'hAAAA_AAAA, 1'b1, 1'b0, 1'b0},
            // bucket full: insert dropped, a stored value found, the dropped one not found
            '{hbvs_pkg::OP_INSERT, 31'h0000_0010, 32'h0000_0003, 1'b1, 1'b0, 1'b1},
            '{hbvs_pkg::OP_SEARCH, 31'h0000_0020, 32'h8000_0000, 1'b1, 1'b1, 1'b0},
            '{hbvs_pkg::OP_SEARCH, 31'h0000_0000, 32'h0000_0003, 1'b1, 1'b0, 1'b0},
            // delete both copies, reuse the freed slots, overflow again
            '{hbvs_pkg::OP_DELETE, 31'h0000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0},
            '{hbvs_pkg::OP_SEARCH, 31'h0000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0},
            '{hbvs_pkg::OP_INSERT, 31'h7FFF_FFF0, 32'h0000_0003, 1'b0, 1'b0, 1'b0},
            '{hbvs_pkg::OP_INSERT, 31'h7FFF_FFF0, 32'h0000_0004, 1'b0, 1'b0, 1'b0},
            '{hbvs_pkg::OP_INSERT, 31'h7FFF_FFF0, 32'h0000_0005, 1'b1, 1'b0, 1'b1},
            // top bucket through the largest key, unused op, then delete and search in bucket 0
            '{hbvs_pkg::OP_SEARCH, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0},
            '{hbvs_pkg::OP_INSERT, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0},
            '{hbvs_pkg::OP_SEARCH, 31'h0000_000F, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0},
            '{OP_UNUSED,           31'h2AAA_AAAA, 32'h5555_5555, 1'b1, 1'b0, 1'b0},
            '{hbvs_pkg::OP_DELETE, 31'h0000_0000, 32'h8000_0000, 1'b0, 1'b0, 1'b0},
            '{hbvs_pkg::OP_SEARCH, 31'h0000_0010, 32'h8000_0000, 1'b0, 1'b0, 1'b0}
        };

        // A small pool of values keeps hits, duplicates and full buckets common
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < 8; i++)
            value_pool[i] = $urandom();

        // Hold reset, then release between edges
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            send_request(directed_rows[i].op, directed_rows[i].key, directed_rows[i].value,
                         directed_rows[i].typed, directed_rows[i].found,
                         directed_rows[i].status);
        end

        // Random requests. The op mix swings between insert-heavy and
        // delete-heavy stretches so buckets keep filling up and draining.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS - QUIET_ITEMS)
                quiet_phase = 1'b1;

            // Hold the request channel until every result is back
            if (n == 250 || n == 500)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            else if (!quiet_phase && $urandom_range(0, 4) == 0)
            begin
                idle_sender($urandom_range(1, 10));
            end

            mix = ((n / 120) % 2 == 0) ? 55 : 30;
            r   = $urandom_range(0, 99);
            if (r < mix)
                rand_op = hbvs_pkg::OP_INSERT;
            else if (r < 70)
                rand_op = hbvs_pkg::OP_DELETE;
            else if (r < 95)
                rand_op = hbvs_pkg::OP_SEARCH;
            else
                rand_op = OP_UNUSED;

            // Mostly a few hot buckets; upper key bits are random either way
            if ($urandom_range(0, 3) != 0)
                bucket = $urandom_range(0, 3);
            else
                bucket = $urandom_range(0, NUM_BUCKETS - 1);
            if ($urandom_range(0, 9) == 0)
                rand_key = hbvs_pkg::KEY_W'($urandom());
            else
                rand_key = (hbvs_pkg::KEY_W'($urandom()) & 31'h7FFF_FFF0) |
                           hbvs_pkg::KEY_W'(bucket);

            if ($urandom_range(0, 4) == 0)
                rand_val = $urandom();
            else
                rand_val = value_pool[$urandom_range(0, 7)];

            send_request(rand_op, rand_key, rand_val, 1'b0, 1'b0, 1'b0);
        end

        // Drain: drop valid, wait for the last results, then let the block settle
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatches == 0)
            $display("[hashed_bucket_value_set_top] OK");
        else
            $display("[hashed_bucket_value_set_top] ERROR");
        $finish;
    end

endmodule
